/* rtl/bdlp_pkg.sv */
// Package for the button debounce / long-press qualifier.
// Item types, register indexes, phase and event codes, reset values.
// No dependencies.
package bdlp_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL    = 2'd2;

    localparam logic [THR_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [THR_W-1:0] LONG_PRESS_RESET = 16'd1000;

    localparam logic FUNC_UPDATE    = 1'b0;
    localparam logic FUNC_GET_EVENT = 1'b1;

    localparam logic [1:0] PHASE_IDLE         = 2'd0;
    localparam logic [1:0] PHASE_DEBOUNCE     = 2'd1;
    localparam logic [1:0] PHASE_PRESSED      = 2'd2;
    localparam logic [1:0] PHASE_WAIT_RELEASE = 2'd3;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_SHORT = 2'd1;
    localparam logic [1:0] EVT_LONG  = 2'd2;

    typedef struct packed {
        logic              func;
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic [1:0] press_state;
    } out_item_t;

endpackage

/* rtl/button_debounce_long_press.sv */
// Top level of the button debounce / long-press qualifier.
// Input register, phase machine with event latch, result register.
// Depends on bdlp_pkg.
//
// Takes one item per clock cycle, sustained while the output is not stalled.
// Each item passes an input register and then the result register, from which
// its result transfers out. The phase machine and event latch update when the
// item moves into the result register, one subtract-and-compare per item.
// Update items (func 0) step the debounce / long-press machine; get-event
// items (func 1) return the latched event and clear it. Every item gives
// exactly one result: the event latched before it and the phase after it.
// Configuration writes are taken at any cycle and are meant for idle times.
module button_debounce_long_press (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bdlp_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bdlp_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdlp_pkg::THR_W-1:0]      cfg_data
);
    import bdlp_pkg::*;

    logic [THR_W-1:0]  debounce_time_reg;
    logic [THR_W-1:0]  long_press_time_reg;
    logic              active_level_reg;

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              s1_adv;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [TIME_W-1:0] start_time_reg;
    logic [TIME_W-1:0] start_time_next;
    logic [1:0]        pending_event_reg;
    logic [1:0]        pending_event_next;

    logic              out_valid_reg;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;

    logic              pressed;
    logic [TIME_W-1:0] elapsed;
    logic              debounce_done;
    logic              long_done;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg   <= DEBOUNCE_RESET;
            long_press_time_reg <= LONG_PRESS_RESET;
            active_level_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_data;
                REG_LONG_PRESS_TIME: long_press_time_reg <= cfg_data;
                REG_ACTIVE_LEVEL:    active_level_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_data;
        end
    end

    assign pressed       = (s1_item_reg.pin_level == active_level_reg);
    assign elapsed       = s1_item_reg.now_ms - start_time_reg;
    assign debounce_done = (elapsed >= {{(TIME_W-THR_W){1'b0}}, debounce_time_reg});
    assign long_done     = (elapsed >= {{(TIME_W-THR_W){1'b0}}, long_press_time_reg});

    always_comb
    begin
        phase_next         = phase_reg;
        start_time_next    = start_time_reg;
        pending_event_next = pending_event_reg;
        if (s1_item_reg.func == FUNC_GET_EVENT)
        begin
            pending_event_next = EVT_NONE;
        end
        else
        begin
            case (phase_reg)
                PHASE_IDLE:
                begin
                    if (pressed)
                    begin
                        phase_next      = PHASE_DEBOUNCE;
                        start_time_next = s1_item_reg.now_ms;
                    end
                end
                PHASE_DEBOUNCE:
                begin
                    if (!pressed)
                    begin
                        phase_next = PHASE_IDLE;
                    end
                    else if (debounce_done)
                    begin
                        phase_next      = PHASE_PRESSED;
                        start_time_next = s1_item_reg.now_ms;
                    end
                end
                PHASE_PRESSED:
                begin
                    if (!pressed)
                    begin
                        pending_event_next = EVT_SHORT;
                        phase_next         = PHASE_IDLE;
                    end
                    else if (long_done)
                    begin
                        pending_event_next = EVT_LONG;
                        phase_next         = PHASE_WAIT_RELEASE;
                    end
                end
                default:
                begin
                    if (!pressed)
                    begin
                        phase_next = PHASE_IDLE;
                    end
                end
            endcase
        end
        out_item_next.event_code  = pending_event_reg;
        out_item_next.press_state = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PHASE_IDLE;
            start_time_reg    <= '0;
            pending_event_reg <= EVT_NONE;
        end
        else if (s1_adv)
        begin
            phase_reg         <= phase_next;
            start_time_reg    <= start_time_next;
            pending_event_reg <= pending_event_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_no_skip_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_IDLE) |=>
            (phase_reg == PHASE_IDLE || phase_reg == PHASE_DEBOUNCE))
        else $error("phase left idle without passing debounce");

    a_long_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && phase_reg == PHASE_PRESSED && phase_next == PHASE_WAIT_RELEASE)
            |=> (pending_event_reg == EVT_LONG))
        else $error("wait-release entered without a long-press event");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> ($stable(phase_reg) && $stable(pending_event_reg)
            && $stable(start_time_reg)))
        else $error("state changed without an item moving to the result register");

endmodule

/* bench/button_debounce_long_press_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for button_debounce_long_press: directed and random press
// episodes over several register settings, checked against an in-bench tracker.
// Depends on bdlp_pkg and the button_debounce_long_press RTL.
module button_debounce_long_press_tb;
    import bdlp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0] cfg_data = '0;

    button_debounce_long_press dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // tracker copy of the block state and registers
    logic [THR_W-1:0] debounce_cfg = DEBOUNCE_RESET;
    logic [THR_W-1:0] long_cfg = LONG_PRESS_RESET;
    logic level_cfg = 1'b0;
    logic [1:0] phase_q = PHASE_IDLE;
    logic [TIME_W-1:0] mark_ms = '0;
    logic [1:0] latched_evt = EVT_NONE;

    in_item_t pending_items[$];
    out_item_t press_reports[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_short = 0;
    int n_long = 0;
    int errors = 0;
    bit took_in = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_hold = 0;
    int stall_cyc = 0;
    bit calm = 1'b0;
    logic [TIME_W-1:0] t_now;
    out_item_t exp_r;

    task automatic track_press(input in_item_t it);
        out_item_t r;
        logic [TIME_W-1:0] elapsed;
        logic held;
        r.event_code = latched_evt;
        if (it.func == FUNC_UPDATE)
        begin
            held = (it.pin_level == level_cfg);
            elapsed = it.now_ms - mark_ms;
            case (phase_q)
                PHASE_IDLE:
                    if (held)
                    begin
                        phase_q = PHASE_DEBOUNCE;
                        mark_ms = it.now_ms;
                    end
                PHASE_DEBOUNCE:
                    if (!held)
                        phase_q = PHASE_IDLE;
                    else if (elapsed >= {16'd0, debounce_cfg})
                    begin
                        phase_q = PHASE_PRESSED;
                        mark_ms = it.now_ms;
                    end
                PHASE_PRESSED:
                    if (!held)
                    begin
                        latched_evt = EVT_SHORT;
                        phase_q = PHASE_IDLE;
                        n_short++;
                    end
                    else if (elapsed >= {16'd0, long_cfg})
                    begin
                        latched_evt = EVT_LONG;
                        phase_q = PHASE_WAIT_RELEASE;
                        n_long++;
                    end
                default:
                    if (!held)
                        phase_q = PHASE_IDLE;
            endcase
        end
        else
            latched_evt = EVT_NONE;
        r.press_state = phase_q;
        press_reports.push_back(r);
    endtask

    // result check first, then input transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (press_reports.size() == 0)
                begin
                    $error("result transfer with no expected report");
                    errors++;
                end
                else
                begin
                    exp_r = press_reports.pop_front();
                    if (out_data.event_code !== exp_r.event_code)
                    begin
                        $error("event_code: expected %0d, actual %0d",
                               exp_r.event_code, out_data.event_code);
                        errors++;
                    end
                    if (out_data.press_state !== exp_r.press_state)
                    begin
                        $error("press_state: expected %0d, actual %0d",
                               exp_r.press_state, out_data.press_state);
                        errors++;
                    end
                    n_checked++;
                end
            end
            took_in = in_valid && !in_stall;
            if (took_in)
            begin
                track_press(in_data);
                n_accepted++;
            end
        end
    end

    // sender: bursts with gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || took_in)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with calm windows
    always @(negedge clk)
    begin
        stall_cyc++;
        if (stall_cyc % 256 == 0)
            calm = ($urandom_range(0, 2) == 0);
        if (stall_hold > 0)
            stall_hold--;
        else
        begin
            out_stall <= calm ? 1'b0 : 1'($urandom_range(0, 1));
            stall_hold = $urandom_range(0, 6);
        end
    end

    task automatic add_item(input logic f, input logic lvl, input logic [TIME_W-1:0] t);
        in_item_t it;
        it.func = f;
        it.pin_level = lvl;
        it.now_ms = t;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic add_update(input logic lvl, input logic [TIME_W-1:0] t);
        add_item(FUNC_UPDATE, lvl, t);
    endtask

    task automatic add_get();
        add_item(FUNC_GET_EVENT, 1'($urandom_range(0, 1)), $urandom);
    endtask

    task automatic add_noise();
        add_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
    endtask

    // idle samples, a held press with optional bounce, then release
    task automatic add_episode();
        longint hold;
        int n;
        logic [TIME_W-1:0] t0;
        logic lvl;
        lvl = level_cfg;
        if ($urandom_range(0, 9) == 0)
            t_now -= $urandom_range(0, 100);
        repeat ($urandom_range(0, 2))
        begin
            t_now += $urandom_range(0, 50);
            add_update(~lvl, t_now);
        end
        case ($urandom_range(0, 3))
            0: hold = longint'($urandom_range(0, debounce_cfg));
            1: hold = longint'(debounce_cfg) + longint'($urandom_range(0, long_cfg));
            default: hold = longint'(debounce_cfg) + longint'(long_cfg)
                            + longint'($urandom_range(0, 3000));
        endcase
        n = $urandom_range(1, 8);
        t0 = t_now;
        for (int i = 0; i <= n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                add_update(~lvl, t0 + 32'(hold * i / n));
            else
                add_update(lvl, t0 + 32'(hold * i / n));
            if ($urandom_range(0, 9) == 0)
                add_get();
        end
        t_now = t0 + 32'(hold);
        repeat ($urandom_range(1, 2))
        begin
            t_now += $urandom_range(0, 30);
            add_update(~lvl, t_now);
        end
        if ($urandom_range(0, 1))
            add_get();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DEBOUNCE_TIME)
            debounce_cfg = val;
        else if (idx == REG_LONG_PRESS_TIME)
            long_cfg = val;
        else if (idx == REG_ACTIVE_LEVEL)
            level_cfg = val[0];
    endtask

    task automatic drain();
        wait (n_checked >= n_queued);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [THR_W-1:0] d_set;
        logic [THR_W-1:0] l_set;
        logic a_set;
        int target;
        t_now = $urandom;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: active low, 20 ms debounce, 1000 ms long press
        add_get();
        add_update(1'b1, 32'd0);
        add_update(1'b0, 32'hFFFF_FFF0);
        add_update(1'b0, 32'd3);
        add_update(1'b0, 32'd4);
        add_update(1'b1, 32'd10);
        add_update(1'b0, 32'd11);
        add_get();
        add_get();
        add_update(1'b0, 32'd31);
        add_update(1'b0, 32'd1030);
        add_update(1'b0, 32'd1031);
        add_update(1'b0, 32'd5000);
        add_update(1'b1, 32'd5001);
        add_update(1'b0, 32'd5002);
        add_update(1'b0, 32'd5001);
        add_update(1'b1, 32'd5002);
        add_get();
        add_update(1'b0, 32'd6000);
        add_update(1'b1, 32'd6001);
        add_update(1'b0, 32'd7000);
        add_get();
        add_update(1'b0, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin d_set = 16'd0;     l_set = 16'd0;     a_set = 1'b1; end
                1: begin d_set = 16'hFFFF;  l_set = 16'hFFFF;  a_set = 1'b0; end
                2: begin d_set = 16'($urandom_range(1, 40));
                         l_set = 16'($urandom_range(1, 200));  a_set = 1'b1; end
                3: begin d_set = 16'd0;     l_set = 16'hFFFF;  a_set = 1'b0; end
                4: begin d_set = 16'hFFFF;  l_set = 16'd0;     a_set = 1'b1; end
                default: begin d_set = 16'($urandom); l_set = 16'($urandom);
                               a_set = 1'($urandom_range(0, 1)); end
            endcase
            write_reg(REG_DEBOUNCE_TIME, d_set);
            write_reg(REG_LONG_PRESS_TIME, l_set);
            write_reg(REG_ACTIVE_LEVEL, {15'($urandom), a_set});
            if (ph == 2)
                write_reg(REG_SPARE, 16'($urandom));
            target = n_queued + 80;
            while (n_queued < target)
            begin
                if ($urandom_range(0, 9) < 8)
                    add_episode();
                else
                    repeat ($urandom_range(1, 4)) add_noise();
            end
            drain();
        end

        repeat (8) @(negedge clk);
        $display("%0d items over 7 register settings, %0d results checked",
                 n_accepted, n_checked);
        $display("tracker saw %0d short and %0d long press events", n_short, n_long);
        if (errors == 0)
            $display("button_debounce_long_press: match");
        else
            $display("button_debounce_long_press: mismatch");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("button_debounce_long_press: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bdlp_pkg.sv
rtl/button_debounce_long_press.sv
bench/button_debounce_long_press_tb.sv
